>>> sv/cdf_pkg.sv
// ============================================================================
// cdf_pkg: shared types and constants for the categorical sampler
// Word formats, command codes and default sizes used by the front, the
// queue and the back end.
// ============================================================================
`default_nettype none
package cdf_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int W_FIELD_BITS    = 16;
    localparam int DRAW_BITS       = 16;
    localparam int CAT_BITS        = 7;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] weight;
        logic        last_weight;
        logic [15:0] draw;
    } in_word_t;

    typedef struct packed {
        logic [6:0] category;
        logic       error;
    } out_word_t;
endpackage
`default_nettype wire

>>> sv/cdf_queue.sv
// ============================================================================
// cdf_queue: two-entry word queue between front and back end
// Registered FIFO with valid/stall on both sides.
// ============================================================================
`default_nettype none
module cdf_queue (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire cdf_pkg::in_word_t in_data,
    input  wire                logic in_valid,
    output logic                     in_stall,
    output cdf_pkg::in_word_t        out_data,
    output logic                     out_valid,
    input  wire                logic out_stall
);
    cdf_pkg::in_word_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign out_data  = mem_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> sv/cdf_back.sv
// ============================================================================
// cdf_back: table store, normalization divider and query scanner
// Executes one word at a time: loads append running sums, the last load
// normalizes each entry with a bit-serial divider, queries scan the table.
// ============================================================================
`default_nettype none
module cdf_back #(
    parameter int TABLE_DEPTH = cdf_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS = cdf_pkg::WEIGHT_BITS_DEF,
    parameter int FRAC_BITS   = cdf_pkg::FRAC_BITS_DEF
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire cdf_pkg::in_word_t in_data,
    input  wire                logic in_valid,
    output logic                     in_stall,
    output cdf_pkg::out_word_t       out_data,
    output logic                     out_valid,
    input  wire                logic out_stall
);
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int SW   = WEIGHT_BITS + CW;
    localparam int EW   = (SW > FRAC_BITS + 1) ? SW : FRAC_BITS + 1;
    localparam int BCW  = $clog2(FRAC_BITS + 1);
    localparam int CMPW = FRAC_BITS + cdf_pkg::DRAW_BITS + 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_NRD   = 7'b0000010,
        ST_NDIV  = 7'b0000100,
        ST_NWR   = 7'b0001000,
        ST_QRD   = 7'b0010000,
        ST_QCMP  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] total_reg;
    logic          ready_reg, fresh_reg;
    logic [CW-1:0] idx_reg;
    logic [SW:0]   rem_reg;
    logic [FRAC_BITS:0] quo_reg;
    logic [BCW-1:0] bit_reg;
    logic [15:0]   draw_reg;
    logic          res_valid_reg;
    cdf_pkg::out_word_t res_reg;

    logic          take;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [SW:0]   rem_sh;
    logic [SW-1:0] new_total;
    logic [CW-1:0] cnt_eff;
    logic [SW-1:0] tot_eff;
    logic [CW-1:0] cnt_new;
    logic [SW-1:0] tot_new;
    logic          q_err;
    logic [SW:0]   num_ext;
    logic [CMPW-1:0] d_ext, e_ext;

    assign in_stall  = (state_reg != ST_IDLE);
    assign take      = in_valid && !in_stall;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign rd_addr   = idx_reg[AW-1:0];
    assign rem_sh    = {rem_reg[SW-1:0], 1'b0};
    assign cnt_eff   = fresh_reg ? '0 : count_reg;
    assign tot_eff   = fresh_reg ? '0 : total_reg;
    assign new_total = tot_eff + SW'(in_data.weight[WEIGHT_BITS-1:0]);
    assign cnt_new   = (cnt_eff < CW'(TABLE_DEPTH)) ? cnt_eff + 1'b1 : cnt_eff;
    assign tot_new   = (cnt_eff < CW'(TABLE_DEPTH)) ? new_total : tot_eff;
    assign q_err     = !ready_reg || fresh_reg == 1'b0 || count_reg == '0
                       || total_reg == '0;
    assign num_ext   = (SW+1)'(rd_data_reg);
    assign d_ext     = CMPW'({draw_reg, {FRAC_BITS{1'b0}}});
    assign e_ext     = CMPW'({rd_data_reg[FRAC_BITS:0], 16'd0});

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Memory write port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_eff[AW-1:0];
        wr_data = EW'(new_total);
        if (state_reg == ST_IDLE)
        begin
            wr_en = take && in_data.cmd == cdf_pkg::CMD_LOAD
                    && cnt_eff < CW'(TABLE_DEPTH);
        end
        else if (state_reg == ST_NWR)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg[AW-1:0];
            wr_data = (idx_reg == count_reg - 1'b1)
                      ? EW'({1'b1, {FRAC_BITS{1'b0}}}) : EW'(quo_reg);
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (in_data.cmd == cdf_pkg::CMD_LOAD)
                    begin
                        if (in_data.last_weight && tot_new != '0 && cnt_new != '0)
                            state_next = ST_NRD;
                    end
                    else
                    begin
                        state_next = q_err ? ST_OUT : ST_QRD;
                    end
                end
            end
            ST_NRD:  state_next = ST_NDIV;
            ST_NDIV: if (bit_reg == BCW'(FRAC_BITS)) state_next = ST_NWR;
            ST_NWR:  state_next = (idx_reg + 1'b1 == count_reg) ? ST_IDLE : ST_NRD;
            ST_QRD:  state_next = (idx_reg == count_reg) ? ST_OUT : ST_QCMP;
            ST_QCMP: state_next = (d_ext > e_ext) ? ST_QRD : ST_OUT;
            ST_OUT:  if (!res_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            ready_reg     <= 1'b0;
            fresh_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            bit_reg       <= '0;
            draw_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid_reg && !out_stall) res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take && in_data.cmd == cdf_pkg::CMD_LOAD)
                    begin
                        count_reg <= cnt_new;
                        total_reg <= tot_new;
                        ready_reg <= in_data.last_weight;
                        fresh_reg <= in_data.last_weight;
                        idx_reg   <= '0;
                    end
                    else if (take)
                    begin
                        draw_reg <= in_data.draw;
                        idx_reg  <= '0;
                        if (q_err)
                        begin
                            res_reg       <= '{category: '0, error: 1'b1};
                            res_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_NRD:
                begin
                    rem_reg <= num_ext;
                    quo_reg <= '0;
                    bit_reg <= '0;
                end
                ST_NDIV:
                begin
                    if (bit_reg == '0)
                    begin
                        // Integer part: one only when the entry equals the total.
                        if (num_ext >= {1'b0, total_reg})
                        begin
                            rem_reg <= num_ext - {1'b0, total_reg};
                            quo_reg <= (FRAC_BITS+1)'(1);
                        end
                        else
                        begin
                            rem_reg <= num_ext;
                            quo_reg <= '0;
                        end
                        bit_reg <= bit_reg + 1'b1;
                    end
                    else if (bit_reg != BCW'(FRAC_BITS))
                    begin
                        if (rem_sh >= {1'b0, total_reg})
                        begin
                            rem_reg <= rem_sh - {1'b0, total_reg};
                            quo_reg <= {quo_reg[FRAC_BITS-1:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[FRAC_BITS-1:0], 1'b0};
                        end
                        bit_reg <= bit_reg + 1'b1;
                    end
                    else
                    begin
                        if (rem_sh >= {1'b0, total_reg})
                            quo_reg <= {quo_reg[FRAC_BITS-1:0], 1'b1};
                        else
                            quo_reg <= {quo_reg[FRAC_BITS-1:0], 1'b0};
                    end
                end
                ST_NWR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_QRD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        res_reg       <= '{category: 7'(idx_reg), error: 1'b0};
                        res_valid_reg <= 1'b1;
                    end
                end
                ST_QCMP:
                begin
                    if (d_ext > e_ext)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        res_reg       <= '{category: 7'(idx_reg), error: 1'b0};
                        res_valid_reg <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/cdf_table_category_sampler_top.sv
// Categorical sampler top level.
// Load word: appends a running sum; the last load adds a bit-serial
// normalization of each entry through the table memory port.
// Query word: the back end scans the table entry by entry until an entry
// matches or the table ends, then registers the answer for handoff.
// Reset clears control state; the table memory is not cleared.
// ============================================================================
// cdf_table_category_sampler_top: front queue plus execution back end
// Words enter a two-entry queue and are carried out by the back end.
// ============================================================================
`default_nettype none
module cdf_table_category_sampler_top #(
    parameter int TABLE_DEPTH = cdf_pkg::TABLE_DEPTH_DEF,
    parameter int WEIGHT_BITS = cdf_pkg::WEIGHT_BITS_DEF,
    parameter int FRAC_BITS   = cdf_pkg::FRAC_BITS_DEF
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire cdf_pkg::in_word_t in_data,
    input  wire                logic in_valid,
    output logic                     in_stall,
    output cdf_pkg::out_word_t       out_data,
    output logic                     out_valid,
    input  wire                logic out_stall
);
    cdf_pkg::in_word_t q_data;
    logic q_valid, q_stall;

    // Front queue.
    cdf_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
        .out_data(q_data), .out_valid(q_valid), .out_stall(q_stall)
    );

    // Back end.
    cdf_back #(
        .TABLE_DEPTH(TABLE_DEPTH), .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_data(q_data), .in_valid(q_valid), .in_stall(q_stall),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
    );

`ifndef ASSERT_OFF
    // An error answer always carries category zero.
    a_err_cat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> out_data.category == '0)
        else $error("error word with nonzero category");
    // A good category never exceeds the table depth.
    a_cat_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.error |-> 32'(out_data.category) <= TABLE_DEPTH)
        else $error("category beyond table depth");
`endif
endmodule
`default_nettype wire
